// File: hw/rtl/brrg_pkg.sv
// ============================================================================
// brrg_pkg: shared definitions for the balanced random row generator
// Sizes, register indexes, interface structs and the saturation helpers that
// clamp the alphabet size and the row length into their legal ranges.
// ============================================================================
`default_nettype none

package brrg_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int MAX_ROW     = 64;

    // Field widths that follow from the sizes above.
    localparam int SYM_W = $clog2(MAX_SYMBOLS);
    localparam int COL_W = $clog2(MAX_ROW);
    localparam int CNT_W = COL_W + 1;

    // Fixed register and stream field widths.
    localparam int NUM_W  = 5;
    localparam int LEN_W  = 7;
    localparam int WORD_W = 31;

    localparam int IN_DATA_W  = ((WORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SYM_W + COL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - SYM_W - COL_W;

    // The serial modulo unit must hold any divisor: a row length or a symbol count.
    localparam int DIV_W     = (CNT_W > SYM_W + 1) ? CNT_W : SYM_W + 1;
    localparam int DIV_CNT_W = $clog2(WORD_W);

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes, decoded from the word address bit paddr[2].
    localparam logic REG_NUM_SYMBOLS = 1'b0;
    localparam logic REG_ROW_LENGTH  = 1'b1;

    localparam logic [NUM_W-1:0] NUM_SYMBOLS_RST = NUM_W'(2);
    localparam logic [LEN_W-1:0] ROW_LENGTH_RST  = LEN_W'(8);

    typedef struct packed {
        logic [NUM_W-1:0] num_symbols;
        logic [LEN_W-1:0] row_length;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] column;
        logic [SYM_W-1:0] symbol;
    } t_result;

    // Alphabet size clamped into 1..MAX_SYMBOLS.
    function automatic logic [SYM_W:0] sat_symbols(input logic [NUM_W-1:0] num);
        logic [SYM_W:0] v;
        if (num == '0) begin
            v = (SYM_W+1)'(1);
        end else if (int'(num) > MAX_SYMBOLS) begin
            v = (SYM_W+1)'(MAX_SYMBOLS);
        end else begin
            v = (SYM_W+1)'(num);
        end
        return v;
    endfunction

    // Row length clamped into 1..MAX_ROW.
    function automatic logic [CNT_W-1:0] sat_row(input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] k;
        if (len == '0) begin
            k = CNT_W'(1);
        end else if (int'(len) > MAX_ROW) begin
            k = CNT_W'(MAX_ROW);
        end else begin
            k = CNT_W'(len);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/brrg_apb_regs.sv
// ============================================================================
// brrg_apb_regs: configuration register file
// Holds the alphabet size and the row length behind an APB-style port. Any
// write raises a restart strobe so that the next random word opens a new row.
// ============================================================================
`default_nettype none

module brrg_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [brrg_pkg::APB_AW-1:0]  paddr,
    input  logic [brrg_pkg::APB_DW-1:0]  pwdata,
    output logic [brrg_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output brrg_pkg::t_cfg               o_cfg
);
    import brrg_pkg::*;

    logic [NUM_W-1:0] r_num_symbols;
    logic [LEN_W-1:0] r_row_length;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_symbols <= NUM_SYMBOLS_RST;
            r_row_length  <= ROW_LENGTH_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_NUM_SYMBOLS: r_num_symbols <= pwdata[NUM_W-1:0];
                REG_ROW_LENGTH:  r_row_length  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_NUM_SYMBOLS: prdata = APB_DW'(r_num_symbols);
            REG_ROW_LENGTH:  prdata = APB_DW'(r_row_length);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.num_symbols = r_num_symbols;
    assign o_cfg.row_length  = r_row_length;
    assign o_cfg.restart     = wr_en;

endmodule

`default_nettype wire

// File: hw/rtl/brrg_serial_mod.sv
// ============================================================================
// brrg_serial_mod: bit-serial restoring divider
// Shifts the dividend in one bit per cycle and produces remainder and the low
// quotient bits once the last bit is in. Shared by every modulo in the block.
// ============================================================================
`default_nettype none

module brrg_serial_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  brrg_pkg::t_div_req  i_req,
    output brrg_pkg::t_div_rsp  o_rsp
);
    import brrg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_dvd;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 fits;
    logic                 last_bit;

    assign trial    = {r_rem, r_dvd[WORD_W-1]};
    assign diff     = trial - {1'b0, r_dvs};
    assign fits     = trial >= {1'b0, r_dvs};
    assign last_bit = r_cnt == DIV_CNT_W'(WORD_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (last_bit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/brrg_sequencer.sv
// ============================================================================
// brrg_sequencer: row sequencer with symbol order and quota tables
// Loads the quotas at the start of a row, runs one shuffle swap per word,
// hands out the extra quotas and picks one symbol per word by a serial scan
// over the running quota sum.
// ============================================================================
`default_nettype none

module brrg_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brrg_pkg::t_cfg                i_cfg,
    input  logic                          i_word_valid,
    output logic                          o_word_ready,
    input  logic [brrg_pkg::WORD_W-1:0]   i_word,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output brrg_pkg::t_result             o_res,
    output brrg_pkg::t_div_req            o_div,
    input  brrg_pkg::t_div_rsp            i_div
);
    import brrg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INIT_DIV = 9'b000000010,
        S_SHUF_DIV = 9'b000000100,
        S_SWAP_RD  = 9'b000001000,
        S_SWAP_WR  = 9'b000010000,
        S_EXTRA    = 9'b000100000,
        S_PICK_DIV = 9'b001000000,
        S_SCAN     = 9'b010000000,
        S_EMIT     = 9'b100000000
    } t_state;

    typedef enum logic [2:0] {
        PH_START   = 3'b001,
        PH_SHUFFLE = 3'b010,
        PH_PICK    = 3'b100
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [WORD_W-1:0] r_word;
    logic [SYM_W-1:0] r_step, n_step;
    logic [SYM_W-1:0] r_b, n_b;
    logic [SYM_W-1:0] r_tmp;
    logic [SYM_W-1:0] r_idx, n_idx;
    logic [SYM_W-1:0] r_extra, n_extra;
    logic [SYM_W-1:0] r_sel, n_sel;
    logic [CNT_W-1:0] r_cols, n_cols;
    logic [COL_W-1:0] r_pick, n_pick;
    logic [CNT_W-1:0] r_cum, n_cum;

    logic [SYM_W-1:0] r_order [MAX_SYMBOLS];
    logic [CNT_W-1:0] r_quota [MAX_SYMBOLS];

    logic [SYM_W:0]   v_eff;
    logic [CNT_W-1:0] k_eff;
    logic [SYM_W-1:0] v_top;
    logic [SYM_W-1:0] order_addr;
    logic [SYM_W-1:0] order_rd;
    logic [SYM_W-1:0] quota_addr;
    logic [CNT_W-1:0] quota_rd;
    logic [CNT_W:0]   cum_sum;
    logic             hit;
    logic [CNT_W-1:0] cols_inc;
    logic             row_last;
    logic             accept;

    logic             init_tables;
    logic             swap_wr;
    logic             extra_wr;
    logic             quota_dec;

    assign v_eff    = sat_symbols(i_cfg.num_symbols);
    assign k_eff    = sat_row(i_cfg.row_length);
    assign v_top    = SYM_W'(v_eff - (SYM_W+1)'(1));
    assign accept   = i_word_valid && o_word_ready;
    assign cols_inc = r_cols + CNT_W'(1);
    assign row_last = cols_inc >= k_eff;

    // One read port per table; the address follows the step at hand.
    always_comb begin
        unique case (r_state)
            S_SWAP_RD: order_addr = r_step;
            S_SWAP_WR: order_addr = r_b;
            default:   order_addr = r_idx;
        endcase
    end
    assign order_rd   = r_order[order_addr];
    assign quota_addr = (r_state == S_EXTRA) ? order_rd : r_idx;
    assign quota_rd   = r_quota[quota_addr];
    assign cum_sum    = {1'b0, r_cum} + {1'b0, quota_rd};
    assign hit        = (CNT_W+1)'(r_pick) < cum_sum;

    assign o_word_ready = r_state == S_IDLE;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_step      = r_step;
        n_b         = r_b;
        n_idx       = r_idx;
        n_extra     = r_extra;
        n_sel       = r_sel;
        n_cols      = r_cols;
        n_pick      = r_pick;
        n_cum       = r_cum;
        o_div       = '0;
        o_res_valid = 1'b0;
        init_tables = 1'b0;
        swap_wr     = 1'b0;
        extra_wr    = 1'b0;
        quota_dec   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_div.start = 1'b1;
                    unique case (r_phase)
                        PH_START: begin
                            o_div.dividend = WORD_W'(k_eff);
                            o_div.divisor  = DIV_W'(v_eff);
                            n_state        = S_INIT_DIV;
                        end
                        PH_SHUFFLE: begin
                            o_div.dividend = i_word;
                            o_div.divisor  = DIV_W'(r_step) + DIV_W'(1);
                            n_state        = S_SHUF_DIV;
                        end
                        PH_PICK: begin
                            o_div.dividend = i_word;
                            o_div.divisor  = DIV_W'(k_eff - r_cols);
                            n_state        = S_PICK_DIV;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INIT_DIV: begin
                if (i_div.done) begin
                    init_tables    = 1'b1;
                    n_extra        = i_div.rem[SYM_W-1:0];
                    o_div.start    = 1'b1;
                    o_div.dividend = r_word;
                    if (v_eff > (SYM_W+1)'(1)) begin
                        n_step        = v_top;
                        n_phase       = PH_SHUFFLE;
                        o_div.divisor = DIV_W'(v_eff);
                        n_state       = S_SHUF_DIV;
                    end else begin
                        n_phase       = PH_PICK;
                        n_cols        = '0;
                        o_div.divisor = DIV_W'(k_eff);
                        n_state       = S_PICK_DIV;
                    end
                end
            end
            S_SHUF_DIV: begin
                if (i_div.done) begin
                    n_b     = i_div.rem[SYM_W-1:0];
                    n_state = S_SWAP_RD;
                end
            end
            S_SWAP_RD: begin
                n_state = S_SWAP_WR;
            end
            S_SWAP_WR: begin
                swap_wr = 1'b1;
                if (r_step <= SYM_W'(1)) begin
                    n_step  = '0;
                    n_idx   = '0;
                    n_state = S_EXTRA;
                end else begin
                    n_step  = r_step - SYM_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_EXTRA: begin
                if (r_idx < r_extra) begin
                    extra_wr = 1'b1;
                    n_idx    = r_idx + SYM_W'(1);
                end else begin
                    n_phase = PH_PICK;
                    n_cols  = '0;
                    n_state = S_IDLE;
                end
            end
            S_PICK_DIV: begin
                if (i_div.done) begin
                    n_pick  = i_div.rem[COL_W-1:0];
                    n_cum   = '0;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_sel     = r_idx;
                    quota_dec = quota_rd != '0;
                    n_state   = S_EMIT;
                end else if (r_idx == v_top) begin
                    // Sum exhausted without a hit: fall back to the top symbol.
                    n_sel   = v_top;
                    n_state = S_EMIT;
                end else begin
                    n_cum = cum_sum[CNT_W-1:0];
                    n_idx = r_idx + SYM_W'(1);
                end
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    if (row_last) begin
                        n_phase = PH_START;
                        n_cols  = '0;
                    end else begin
                        n_cols = cols_inc;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Users must write a register only while idle (the block does not enforce it); a write restarts the row.
        if (i_cfg.restart) begin
            n_phase = PH_START;
        end
    end

    assign o_res.symbol = r_sel;
    assign o_res.column = r_cols[COL_W-1:0];
    assign o_res.last   = row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_START;
            r_step  <= '0;
            r_cols  <= '0;
            r_idx   <= '0;
            r_extra <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_step  <= n_step;
            r_cols  <= n_cols;
            r_idx   <= n_idx;
            r_extra <= n_extra;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b    <= n_b;
        r_sel  <= n_sel;
        r_pick <= n_pick;
        r_cum  <= n_cum;
        if (accept) begin
            r_word <= i_word;
        end
        if (r_state == S_SWAP_RD) begin
            r_tmp <= order_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (init_tables) begin
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                r_order[i] <= SYM_W'(i);
                r_quota[i] <= (i < int'(v_eff)) ? i_div.quo[CNT_W-1:0] : '0;
            end
        end else begin
            if (swap_wr) begin
                r_order[r_step] <= order_rd;
                r_order[r_b]    <= r_tmp;
            end
            if (extra_wr) begin
                r_quota[quota_addr] <= quota_rd + CNT_W'(1);
            end
            if (quota_dec) begin
                r_quota[quota_addr] <= quota_rd - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/balanced_random_row_generator_top.sv
// ============================================================================
// balanced_random_row_generator_top: balanced random row generator
// Turns a stream of random words into rows in which every symbol appears a
// balanced number of times, in shuffled order.
// ============================================================================
//
//   Channel  Direction  Payload                               Handshake
//   s_axis   in         tdata[30:0] random_word               tvalid/tready
//   m_axis   out        tdata[3:0] symbol, [9:4] column_index tvalid/tready
//                       tlast last_in_row
//   apb      in/out     num_symbols at 0x0, row_length at 0x4 psel/penable
//
// Every word goes through one shared bit-serial modulo unit that resolves one
// quotient bit per cycle. A shuffle word runs a division, a swap read and a
// swap write and gives no result; a pick word runs a division, then scans
// the quota sum one symbol at a time and hands the result out. The first
// word of a row also runs the base quota division, and the last shuffle word
// hands out the extra quotas one at a time and then closes the shuffle.
// Reset is synchronous and active low; it restores num_symbols = 2 and
// row_length = 8 and opens a new row. A finished pick waits in an output
// register, so a new random word is taken while the result is still stalled;
// a second pick waits only if that register has not been emptied.
// ============================================================================
`default_nettype none

module balanced_random_row_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // random word request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [brrg_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [30:0] random_word, [31] zero
    // column result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [brrg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [3:0] symbol, [9:4] column_index
    output logic                              m_axis_tlast,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brrg_pkg::APB_AW-1:0]       paddr,
    input  logic [brrg_pkg::APB_DW-1:0]       pwdata,
    output logic [brrg_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import brrg_pkg::*;

    t_cfg      cfg;
    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_result   res;
    logic      res_valid;
    logic      res_ready;

    logic      r_out_valid;
    t_result   r_out;

    brrg_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    brrg_serial_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    brrg_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_word_valid (s_axis_tvalid),
        .o_word_ready (s_axis_tready),
        .i_word       (s_axis_tdata[WORD_W-1:0]),
        .i_res_ready  (res_ready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_div        (div_req),
        .i_div        (div_rsp)
    );

    // Output register: the sequencer may hand over a new result whenever the
    // register is empty or is being emptied in the same cycle.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.column, r_out.symbol};
    assign m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// File: hw/rtl/brrg_checker.sv
// ============================================================================
// brrg_port_checks: port-level checks for the balanced random row generator
// Follows the register writes and the result stream and checks symbol range,
// column numbering, the row end flag and that a stalled result is held.
// ============================================================================
`default_nettype none

module brrg_port_checks (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [brrg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brrg_pkg::APB_AW-1:0]       paddr,
    input  logic [brrg_pkg::APB_DW-1:0]       pwdata,
    input  logic                              pready
);
    import brrg_pkg::*;

    logic [NUM_W-1:0] r_num;
    logic [LEN_W-1:0] r_len;
    logic [COL_W-1:0] r_expect_col;

    logic             cfg_wr;
    logic             out_acc;
    logic [SYM_W-1:0] out_sym;
    logic [COL_W-1:0] out_col;
    logic [SYM_W:0]   v_eff;
    logic [COL_W-1:0] col_top;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign out_sym = m_axis_tdata[SYM_W-1:0];
    assign out_col = m_axis_tdata[SYM_W+COL_W-1:SYM_W];
    assign v_eff   = sat_symbols(r_num);
    assign col_top = COL_W'(sat_row(r_len) - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num        <= NUM_SYMBOLS_RST;
            r_len        <= ROW_LENGTH_RST;
            r_expect_col <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_NUM_SYMBOLS) begin
                r_num <= pwdata[NUM_W-1:0];
            end else begin
                r_len <= pwdata[LEN_W-1:0];
            end
            r_expect_col <= '0;
        end else if (out_acc) begin
            r_expect_col <= m_axis_tlast ? '0 : out_col + COL_W'(1);
        end
    end

    a_symbol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (SYM_W+1)'(out_sym) < v_eff)
        else $error("symbol outside the configured alphabet");

    a_column_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> out_col == r_expect_col)
        else $error("column index out of sequence");

    a_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> m_axis_tlast == (out_col == col_top))
        else $error("row end flag does not match the row length");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind balanced_random_row_generator_top brrg_port_checks u_brrg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready)
);

`default_nettype wire

// File: test/brrg_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// brrg_checker: row prediction and column checking
// Watches the configuration writes, the random word requests and the column
// results of the balanced random row generator, keeps its own copy of the
// shuffle and quota state, and compares every column with the oldest
// predicted one.
// ============================================================================

module brrg_checker
    import brrg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [30:0] random_word, [31] zero
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,   // [3:0] symbol, [9:4] column_index
    input  logic                  i_m_axis_tlast,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_AW-1:0]     i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    input  logic                  i_pready,
    output int                    o_error_count,
    output int                    o_pending
);

    typedef enum logic [1:0] {
        ROW_START,
        ROW_SHUFFLE,
        ROW_PICK
    } t_row_phase;

    logic [NUM_W-1:0] num_cfg;
    logic [LEN_W-1:0] len_cfg;
    logic [SYM_W-1:0] sym_order [MAX_SYMBOLS];
    logic [LEN_W-1:0] sym_quota [MAX_SYMBOLS];
    t_row_phase       row_phase;
    logic [SYM_W-1:0] shuffle_idx;
    logic [LEN_W-1:0] cols_done;

    t_result expected_cols [$];
    t_result predicted;
    t_result wanted;

    // Quotas are complete once the shuffled order is known: the first k mod v
    // symbols in that order get one column more than the rest.
    function automatic void open_picks(input int unsigned v, input int unsigned k);
        int unsigned i;
        for (i = 0; i < k % v; i++) begin
            sym_quota[sym_order[i]]++;
        end
        row_phase = ROW_PICK;
        cols_done = '0;
    endfunction

    // Advances the row state by one random word; returns one when the word
    // picks a column, with the column in res.
    function automatic bit predict_column(input logic [WORD_W-1:0] word,
                                          output t_result res);
        int unsigned v, k, a, b, done, left, pick, cum, sel, i;
        logic [SYM_W-1:0] tmp;
        bit found;
        res = '0;
        v = (num_cfg == 0) ? 1 : ((num_cfg > MAX_SYMBOLS) ? MAX_SYMBOLS : num_cfg);
        k = (len_cfg == 0) ? 1 : ((len_cfg > MAX_ROW) ? MAX_ROW : len_cfg);

        if (row_phase == ROW_START) begin
            for (i = 0; i < MAX_SYMBOLS; i++) begin
                sym_order[i] = SYM_W'(i);
                sym_quota[i] = (i < v) ? LEN_W'(k / v) : '0;
            end
            if (v > 1) begin
                shuffle_idx = SYM_W'(v - 1);
                row_phase   = ROW_SHUFFLE;
            end else begin
                // A single symbol needs no shuffle; this word is already a pick.
                open_picks(v, k);
            end
        end

        if (row_phase == ROW_SHUFFLE) begin
            a = shuffle_idx;
            if (a >= v) a = v - 1;
            if (a >= 1) begin
                b            = word % (a + 1);
                tmp          = sym_order[a];
                sym_order[a] = sym_order[b];
                sym_order[b] = tmp;
            end
            if (a <= 1) begin
                shuffle_idx = '0;
                open_picks(v, k);
            end else begin
                shuffle_idx = SYM_W'(a - 1);
            end
            return 1'b0;
        end

        done = cols_done;
        if (done >= k) done = k - 1;
        left  = k - done;
        pick  = word % left;
        cum   = 0;
        sel   = v - 1;
        found = 1'b0;
        for (i = 0; i < v && !found; i++) begin
            cum += sym_quota[i];
            if (pick < cum) begin
                sel   = i;
                found = 1'b1;
            end
        end
        // Without a hit the last symbol goes out and no quota is spent.
        if (found && sym_quota[sel] != 0) sym_quota[sel]--;
        res.symbol = SYM_W'(sel);
        res.column = COL_W'(done);
        res.last   = (done + 1 >= k);
        if (res.last) begin
            row_phase = ROW_START;
            cols_done = '0;
        end else begin
            cols_done = LEN_W'(done + 1);
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            num_cfg     = NUM_SYMBOLS_RST;
            len_cfg     = ROW_LENGTH_RST;
            row_phase   = ROW_START;
            shuffle_idx = '0;
            cols_done   = '0;
            for (int i = 0; i < MAX_SYMBOLS; i++) begin
                sym_order[i] = SYM_W'(i);
                sym_quota[i] = '0;
            end
            expected_cols.delete();
        end else begin
            // Any register write throws away the row in progress.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_NUM_SYMBOLS) begin
                    num_cfg = i_pwdata[NUM_W-1:0];
                end else begin
                    len_cfg = i_pwdata[LEN_W-1:0];
                end
                row_phase = ROW_START;
            end

            // Results are checked before this edge's word is predicted, so a
            // column never meets an expectation younger than itself.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_cols.size() == 0) begin
                    $display("%0t: column with none expected: sym %0d col %0d last %0d",
                             $time, i_m_axis_tdata[SYM_W-1:0],
                             i_m_axis_tdata[SYM_W+COL_W-1:SYM_W], i_m_axis_tlast);
                    o_error_count++;
                end else begin
                    wanted = expected_cols.pop_front();
                    if (i_m_axis_tdata[SYM_W-1:0] !== wanted.symbol ||
                        i_m_axis_tdata[SYM_W+COL_W-1:SYM_W] !== wanted.column ||
                        i_m_axis_tlast !== wanted.last) begin
                        $display("%0t: column mismatch: expected sym %0d col %0d last %0d,",
                                 $time, wanted.symbol, wanted.column, wanted.last,
                                 " got sym %0d col %0d last %0d",
                                 i_m_axis_tdata[SYM_W-1:0],
                                 i_m_axis_tdata[SYM_W+COL_W-1:SYM_W], i_m_axis_tlast);
                        o_error_count++;
                    end
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (predict_column(i_s_axis_tdata[WORD_W-1:0], predicted)) begin
                    expected_cols.push_back(predicted);
                end
            end
        end
        o_pending = expected_cols.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: balanced random row generator testbench
// Drives random word requests and register writes into the generator, lets
// the result side stall at random, and leaves prediction and comparison of
// every column to the checker beside the block.
// ============================================================================

module tb_top;
    import brrg_pkg::*;

    // The slowest item is the first word of a row, which also divides the row
    // length. The limit has to cover a correct run with sender gaps, result
    // stalls and the settle after every phase.
    localparam int LIMIT_CYCLES = 800000;
    // Cycles to let a word that gives no result finish before a register write.
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS = 500;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_AW-1:0]     paddr   = '0;
    logic [APB_DW-1:0]     pwdata  = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int error_count;
    int pending;
    int cycle_count = 0;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Register values last written, needed to size the rows sent.
    logic [NUM_W-1:0] cur_num = NUM_SYMBOLS_RST;
    logic [LEN_W-1:0] cur_len = ROW_LENGTH_RST;

    always #5 i_clk = ~i_clk;

    balanced_random_row_generator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    brrg_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    // The result side decides each cycle whether to take a column. With no
    // stall percentage set it takes one every cycle.
    always @(posedge i_clk) begin
        if (stall_pct == 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: a hung handshake or a lost column ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // One request: optional idle cycles first, then the word is held until the
    // generator takes it. Returns at the edge that accepted the word, with
    // tvalid still high so a following request keeps it up without a glitch.
    task automatic send_word(input logic [WORD_W-1:0] word);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(word);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge that sees
    // psel, penable and pready together.
    task automatic reg_write(input logic reg_sel, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_NUM_SYMBOLS) begin
            cur_num = value[NUM_W-1:0];
        end else begin
            cur_len = value[LEN_W-1:0];
        end
    endtask

    // Stops sending and waits until every predicted column has come back. The
    // pending count is read at the falling edge, when the checker has settled.
    // Shuffle words give nothing to wait for, so a fixed settle follows to let
    // the last of them finish inside the block.
    task automatic drain_rows();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int               random_items;
        int               phase_no;
        int               roll;
        int               veff;
        int               keff;
        int               row_words;
        int               n_words;
        logic [NUM_W-1:0] num_w;
        logic [LEN_W-1:0] len_w;
        logic [WORD_W-1:0] word;

        random_items = 0;
        phase_no     = 0;

        // Reset is held from the start, released once and never asserted again.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ------------------------------------------------------------------
        // Directed part.
        // ------------------------------------------------------------------

        // Reset values, two symbols over eight columns: one shuffle request,
        // then eight picks with extreme and alternating words.
        send_word(31'h7FFF_FFFF);
        send_word(31'h0000_0000);
        send_word(31'h7FFF_FFFF);
        send_word(31'h5555_5555);
        send_word(31'h2AAA_AAAA);
        send_word(31'h0000_0000);
        send_word(31'h7FFF_FFFF);
        send_word(31'h0000_0001);
        send_word(31'h0000_0002);
        drain_rows();

        // A single symbol: no shuffle requests, the first word is a pick.
        reg_write(REG_NUM_SYMBOLS, 32'd1);
        reg_write(REG_ROW_LENGTH, 32'd3);
        send_word(31'h0000_0000);
        send_word(31'h7FFF_FFFF);
        send_word(31'h0123_4567);
        drain_rows();

        // Largest legal sizes: a few shuffle requests, then the row is
        // abandoned by a register write while still shuffling.
        reg_write(REG_NUM_SYMBOLS, 32'd16);
        reg_write(REG_ROW_LENGTH, 32'd64);
        send_word(31'h0000_0000);
        send_word(31'h7FFF_FFFF);
        send_word(31'h5555_5555);
        send_word(31'h2AAA_AAAA);
        drain_rows();

        // Zero in both registers saturates to one symbol in one column, so
        // every word closes a row.
        reg_write(REG_NUM_SYMBOLS, 32'd0);
        reg_write(REG_ROW_LENGTH, 32'd0);
        send_word(31'h7FFF_FFFF);
        send_word(31'h0000_0000);
        drain_rows();

        // All ones in the register bits saturates to the largest sizes.
        reg_write(REG_NUM_SYMBOLS, 32'hFFFF_FFFF);
        reg_write(REG_ROW_LENGTH, 32'hFFFF_FFFF);
        send_word(31'h7FFF_FFFF);
        send_word(31'h0000_0003);
        send_word(31'h0000_0000);
        drain_rows();

        // These register writes also abort the half shuffled row above.
        reg_write(REG_NUM_SYMBOLS, 32'd3);
        reg_write(REG_ROW_LENGTH, 32'd2);
        send_word(31'h0000_0001);
        send_word(31'h7FFF_FFFF);
        send_word(31'h0000_0002);
        send_word(31'h0000_0000);
        drain_rows();

        // ------------------------------------------------------------------
        // Random part: phases of whole rows with random content, some with a
        // trailing partial row. Each phase runs under one pressure mode, and
        // the modes take turns: none, sender idle, receiver stall, both.
        // ------------------------------------------------------------------
        while (random_items < RANDOM_ITEMS) begin
            case (phase_no % 4)
                0: begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  <= 60;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  <= 0;
                    stall_pct <= 60;
                end
                default: begin
                    idle_pct  <= 21;
                    stall_pct <= 21;
                end
            endcase

            // Mostly small alphabets and short rows, now and then the largest
            // or an out-of-range value that the block has to saturate.
            roll = $urandom_range(99);
            if (roll < 60) begin
                num_w = NUM_W'($urandom_range(1, 6));
            end else if (roll < 85) begin
                num_w = NUM_W'($urandom_range(7, 16));
            end else begin
                num_w = $urandom_range(1) ? '0 : NUM_W'($urandom_range(17, 31));
            end
            roll = $urandom_range(99);
            if (roll < 70) begin
                len_w = LEN_W'($urandom_range(1, 12));
            end else if (roll < 90) begin
                len_w = LEN_W'($urandom_range(13, 64));
            end else begin
                len_w = $urandom_range(1) ? '0 : LEN_W'($urandom_range(65, 127));
            end

            // Some phases keep the old settings, so a partial row carries on.
            roll = $urandom_range(99);
            if (roll >= 15) begin
                if (roll < 30) begin
                    if ($urandom_range(1)) reg_write(REG_NUM_SYMBOLS, APB_DW'(num_w));
                    else reg_write(REG_ROW_LENGTH, APB_DW'(len_w));
                end else begin
                    reg_write(REG_NUM_SYMBOLS, APB_DW'(num_w));
                    reg_write(REG_ROW_LENGTH, APB_DW'(len_w));
                end
            end

            veff = (cur_num == 0) ? 1 : ((cur_num > MAX_SYMBOLS) ? MAX_SYMBOLS : cur_num);
            keff = (cur_len == 0) ? 1 : ((cur_len > MAX_ROW) ? MAX_ROW : cur_len);
            row_words = veff - 1 + keff;
            n_words = ((keff > 32) ? 1 : $urandom_range(1, 3)) * row_words;
            if ($urandom_range(4) == 0) begin
                n_words += $urandom_range(1, row_words);
            end

            for (int n = 0; n < n_words; n++) begin
                case ($urandom_range(7))
                    0: word = WORD_W'($urandom_range(63));
                    1: word = {WORD_W{1'b1}} - WORD_W'($urandom_range(63));
                    default: word = WORD_W'($urandom());
                endcase
                send_word(word);
                random_items++;
            end

            // Every phase ends with the sender paused until all columns are in.
            drain_rows();
            phase_no++;
        end

        // drain_rows has already waited for the last column and let the block
        // settle, so any stray column would have been counted by now.
        if (error_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/brrg_pkg.sv
hw/rtl/brrg_apb_regs.sv
hw/rtl/brrg_serial_mod.sv
hw/rtl/brrg_sequencer.sv
hw/rtl/balanced_random_row_generator_top.sv
hw/rtl/brrg_checker.sv
test/brrg_checker.sv
test/tb_top.sv
